// ----- rtl/kwm_pkg.sv -----
package kwm_pkg;

   localparam int MAX_PARTITIONS = 16;
   localparam int IDX_W = $clog2(MAX_PARTITIONS);
   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
   localparam int LEVELS = IDX_W;
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CSR_W = 5;
   localparam int KEY_W = 32;
   localparam int PAY_W = 32;

   typedef struct packed {
      logic [IDX_W-1:0]        source_partition;
      logic signed [KEY_W-1:0] in_key;
      logic [PAY_W-1:0]        in_payload;
      logic                    partition_end;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] out_key;
      logic [PAY_W-1:0]        out_payload;
      logic [IDX_W-1:0]        out_source;
      logic                    merge_done;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic any_pending;
      logic slot_free;
   } status_type;

   typedef struct packed {
      logic                    live;
      logic [IDX_W-1:0]        idx;
      logic signed [KEY_W-1:0] key;
   } cand_type;

endpackage

// ----- rtl/k_way_merge_winner_tree.sv -----
// K-way merge of up to 16 sorted streams through a winner tree. Each req beat
// carries one record or an end mark for one partition; beats for a partition
// that is not awaited, or beyond the active count, are dropped. A beat that
// leaves some active partition still awaited goes from the check state back
// to idle. The beat that completes the leaf set loads the leaves into the
// tree: one shared level of comparators steps through the tree one level
// per cycle, and the result is then loaded into the rsp register, which
// waits while a previous result is not yet taken. A done beat ends each merge
// and rearms all partitions. Write csr only while idle.
module k_way_merge_winner_tree (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kwm_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kwm_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [kwm_pkg::CSR_W-1:0] csr_wdata
);
   import kwm_pkg::*;

   cmd_type    cmd;
   status_type sts;

   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kwm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/kwm_ctrl.sv -----
module kwm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kwm_pkg::status_type sts,
   output kwm_pkg::cmd_type    cmd
);
   import kwm_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CHECK  = 2'd1;
   localparam logic [1:0] S_REDUCE = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.write = 1'b1;
               if (sts.hit) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.any_pending) begin
               state_in = S_IDLE;
            end else begin
               cmd.load = 1'b1;
               lvl_in   = '0;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.step = 1'b1;
            lvl_in   = lvl_ff + LVL_W'(1);
            if (lvl_ff == LVL_W'(LEVELS - 1)) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

endmodule

// ----- rtl/kwm_datapath.sv -----
module kwm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  kwm_pkg::req_type       req_data,
   input  logic                   csr_we,
   input  logic [kwm_pkg::CSR_W-1:0] csr_wdata,
   input  kwm_pkg::cmd_type       cmd,
   output kwm_pkg::status_type    sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output kwm_pkg::rsp_type       rsp_data
);
   import kwm_pkg::*;

   logic [CSR_W-1:0]        active_ff, active_in;
   logic [CNT_W-1:0]        n_cnt;
   logic [MAX_PARTITIONS-1:0] pending_ff, pending_in;
   logic [MAX_PARTITIONS-1:0] exhausted_ff, exhausted_in;
   logic [MAX_PARTITIONS-1:0] active_mask;
   logic signed [KEY_W-1:0] leaf_key_ff [MAX_PARTITIONS];
   logic [PAY_W-1:0]        leaf_payload_ff [MAX_PARTITIONS];
   cand_type                cand_ff [MAX_PARTITIONS];
   cand_type                cand_in [MAX_PARTITIONS];
   cand_type                root;
   logic                    hit;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   assign active_in = csr_we ? csr_wdata : active_ff;

   always_comb begin
      if (active_ff == '0) begin
         n_cnt = CNT_W'(1);
      end else if (active_ff > CSR_W'(MAX_PARTITIONS)) begin
         n_cnt = CNT_W'(MAX_PARTITIONS);
      end else begin
         n_cnt = CNT_W'(active_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
         active_mask[i] = (CNT_W'(i) < n_cnt);
      end
   end

   assign hit = (CNT_W'(req_data.source_partition) < n_cnt)
                && pending_ff[req_data.source_partition];
   assign root = cand_ff[0];

   assign sts.hit         = hit;
   assign sts.any_pending = |(pending_ff & active_mask);
   assign sts.slot_free   = !rsp_valid_ff || rsp_ready;

   // one tree level per step; the live right child wins on a dead left or a smaller key
   always_comb begin
      for (int j = 0; j < MAX_PARTITIONS; j++) begin
         cand_in[j] = cand_ff[j];
      end
      if (cmd.load) begin
         for (int j = 0; j < MAX_PARTITIONS; j++) begin
            cand_in[j].live = active_mask[j] && !exhausted_ff[j];
            cand_in[j].idx  = IDX_W'(j);
            cand_in[j].key  = leaf_key_ff[j];
         end
      end else if (cmd.step) begin
         for (int j = 0; j < MAX_PARTITIONS / 2; j++) begin
            if (cand_ff[2*j+1].live
                && (!cand_ff[2*j].live || (cand_ff[2*j+1].key < cand_ff[2*j].key))) begin
               cand_in[j] = cand_ff[2*j+1];
            end else begin
               cand_in[j] = cand_ff[2*j];
            end
         end
      end
   end

   always_comb begin
      pending_in   = pending_ff;
      exhausted_in = exhausted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.write && hit) begin
         pending_in[req_data.source_partition] = 1'b0;
         if (req_data.partition_end) exhausted_in[req_data.source_partition] = 1'b1;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (!root.live) begin
            rsp_data_in            = '0;
            rsp_data_in.merge_done = 1'b1;
            exhausted_in           = '0;
            pending_in             = '1;
         end else begin
            rsp_data_in.out_key     = root.key;
            rsp_data_in.out_payload = leaf_payload_ff[root.idx];
            rsp_data_in.out_source  = root.idx;
            rsp_data_in.merge_done  = 1'b0;
            pending_in[root.idx]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= CSR_W'(16);
         pending_ff   <= '1;
         exhausted_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         exhausted_ff <= exhausted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int j = 0; j < MAX_PARTITIONS; j++) begin
         cand_ff[j] <= cand_in[j];
      end
      if (cmd.write && hit && !req_data.partition_end) begin
         leaf_key_ff[req_data.source_partition]     <= req_data.in_key;
         leaf_payload_ff[req_data.source_partition] <= req_data.in_payload;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import kwm_pkg::*;

   localparam logic signed [KEY_W-1:0] KEY_TOP    = 32'sh7fff_ffff;
   localparam logic signed [KEY_W-1:0] KEY_BOTTOM = 32'sh8000_0000;
   localparam int SETTLE_CYCLES = 24;
   localparam int FEED_DEPTH = 12;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_W-1:0]    csr_wdata;

   // merge predictor state
   logic [CSR_W-1:0]        active_csr;
   logic signed [KEY_W-1:0] held_key [MAX_PARTITIONS];
   logic [PAY_W-1:0]        held_pay [MAX_PARTITIONS];
   bit                      lane_ended [MAX_PARTITIONS];
   bit                      lane_waiting [MAX_PARTITIONS];
   bit                      merge_finished;
   int                      records_taken;

   rsp_type merged_expected [$];
   int      mismatch_count;

   // per-partition sorted record feeds for well-formed merges
   int feed_key [MAX_PARTITIONS][FEED_DEPTH];
   int feed_len [MAX_PARTITIONS];
   int feed_pos [MAX_PARTITIONS];

   int idle_pct;
   int stall_pct;

   k_way_merge_winner_tree i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic int merge_width();
      int n;
      n = int'(active_csr);
      if (n == 0) n = 1;
      if (n > MAX_PARTITIONS) n = MAX_PARTITIONS;
      return n;
   endfunction

   function automatic bit lane_live(int p, int n);
      return (p < n) && !lane_ended[p];
   endfunction

   // a beats b: a live lane first, then smaller key, lower partition on a tie
   function automatic bit lane_wins(int a, int b, int n);
      if (!lane_live(a, n)) return 1'b0;
      if (!lane_live(b, n)) return 1'b1;
      if (held_key[a] != held_key[b]) return held_key[a] < held_key[b];
      return a < b;
   endfunction

   task automatic predict_merge(input req_type beat);
      int      n;
      int      p;
      int      i;
      int      w;
      int      node [2*MAX_PARTITIONS];
      rsp_type res;
      n = merge_width();
      p = int'(beat.source_partition);
      if (p >= n || !lane_waiting[p]) return;
      records_taken++;
      lane_waiting[p] = 1'b0;
      if (beat.partition_end) begin
         lane_ended[p] = 1'b1;
      end else begin
         held_key[p] = beat.in_key;
         held_pay[p] = beat.in_payload;
      end
      for (i = 0; i < n; i++) begin
         if (lane_waiting[i]) return;
      end
      for (i = 0; i < MAX_PARTITIONS; i++) node[MAX_PARTITIONS+i] = i;
      for (i = MAX_PARTITIONS - 1; i > 0; i--) begin
         node[i] = lane_wins(node[2*i+1], node[2*i], n) ? node[2*i+1] : node[2*i];
      end
      w = node[1];
      res = '0;
      if (!lane_live(w, n)) begin
         res.merge_done = 1'b1;
         for (i = 0; i < MAX_PARTITIONS; i++) begin
            lane_ended[i] = 1'b0;
            lane_waiting[i] = 1'b1;
         end
         merge_finished = 1'b1;
      end else begin
         res.out_key = held_key[w];
         res.out_payload = held_pay[w];
         res.out_source = w[IDX_W-1:0];
         lane_waiting[w] = 1'b1;
      end
      merged_expected.push_back(res);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (merged_expected.size() == 0) begin
            $display("%0t: unexpected rsp beat key=%0d pay=%h src=%0d done=%b", $time,
                     rsp_data.out_key, rsp_data.out_payload, rsp_data.out_source,
                     rsp_data.merge_done);
            mismatch_count++;
         end else begin
            want = merged_expected.pop_front();
            if (rsp_data.out_key !== want.out_key ||
                rsp_data.out_payload !== want.out_payload ||
                rsp_data.out_source !== want.out_source ||
                rsp_data.merge_done !== want.merge_done) begin
               $display("%0t: rsp mismatch expected key=%0d pay=%h src=%0d done=%b",
                        $time, want.out_key, want.out_payload, want.out_source,
                        want.merge_done);
               $display("%0t:              actual   key=%0d pay=%h src=%0d done=%b",
                        $time, rsp_data.out_key, rsp_data.out_payload,
                        rsp_data.out_source, rsp_data.merge_done);
               mismatch_count++;
            end
         end
      end
   end

   // called and returns at a falling edge; req_valid stays high after the beat
   // so a following beat can go out back to back
   task automatic send_beat(input req_type beat, input bit pause);
      if (pause || $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while (pause && merged_expected.size() != 0) @(negedge clock);
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_merge(beat);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (merged_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_active(input int value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      active_csr = value[CSR_W-1:0];
   endtask

   function automatic req_type make_beat(int p, logic signed [KEY_W-1:0] k,
                                         logic [PAY_W-1:0] pay, bit last);
      req_type b;
      b.source_partition = p[IDX_W-1:0];
      b.in_key = k;
      b.in_payload = pay;
      b.partition_end = last;
      return b;
   endfunction

   task automatic test_ties_and_extremes();
      write_active(3);
      send_beat(make_beat(2, KEY_BOTTOM, 32'hffff_ffff, 1'b0), 1'b0);
      send_beat(make_beat(2, 0, 32'h1234_5678, 1'b0), 1'b0);
      send_beat(make_beat(15, -7, 32'h0, 1'b0), 1'b0);
      send_beat(make_beat(0, KEY_TOP, 32'h0, 1'b0), 1'b0);
      send_beat(make_beat(1, KEY_TOP, 32'h1, 1'b0), 1'b0);
      send_beat(make_beat(2, KEY_TOP, 32'h2, 1'b0), 1'b0);
      send_beat(make_beat(0, 32'sh5555_aaaa, 32'hdead_beef, 1'b1), 1'b0);
      send_beat(make_beat(1, 0, 32'h0, 1'b1), 1'b0);
      send_beat(make_beat(2, -1, 32'hffff_ffff, 1'b1), 1'b0);
   endtask

   task automatic test_width_edges();
      // zero width acts as one partition
      write_active(0);
      send_beat(make_beat(0, -1, 32'h5, 1'b0), 1'b0);
      send_beat(make_beat(1, 4, 32'h6, 1'b0), 1'b0);
      send_beat(make_beat(0, 0, 32'h0, 1'b1), 1'b0);
      // width drops and recovers in the middle of a merge
      write_active(2);
      send_beat(make_beat(0, 7, 32'haaaa_5555, 1'b0), 1'b0);
      write_active(1);
      send_beat(make_beat(0, 9, 32'h9, 1'b0), 1'b0);
      write_active(2);
      send_beat(make_beat(1, 3, 32'h3, 1'b0), 1'b0);
      send_beat(make_beat(1, 32'sh7777_0000, 32'hcafe_f00d, 1'b1), 1'b0);
      send_beat(make_beat(0, 0, 32'h0, 1'b1), 1'b0);
      // every partition empty from the start
      send_beat(make_beat(1, 0, 32'h0, 1'b1), 1'b0);
      send_beat(make_beat(0, 0, 32'h0, 1'b1), 1'b0);
   endtask

   task automatic test_random_merges();
      int csr_pick [8];
      int mode;
      int slot;
      int goal;
      int chunk;
      int key_style;
      int p;
      int i;
      int j;
      int k;
      int n;
      int nc;
      int cand [MAX_PARTITIONS];
      req_type beat;
      csr_pick = '{1, 16, 31, 0, 2, 5, 17, 9};
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         goal = records_taken + 375;
         slot = 0;
         while (records_taken < goal) begin
            write_active((slot < 8) ? csr_pick[slot] : $urandom_range(31));
            slot++;
            chunk = records_taken + 90;
            while (records_taken < chunk && records_taken < goal) begin
               key_style = $urandom_range(2);
               for (p = 0; p < MAX_PARTITIONS; p++) begin
                  feed_len[p] = ($urandom_range(9) == 0) ? $urandom_range(FEED_DEPTH - 1)
                                                         : $urandom_range(4);
                  feed_pos[p] = 0;
                  for (i = 0; i < feed_len[p]; i++) begin
                     case (key_style)
                        0: k = $urandom;
                        1: k = $urandom_range(8) - 4;
                        default: begin
                           case ($urandom_range(3))
                              0: k = KEY_BOTTOM;
                              1: k = -1;
                              2: k = 0;
                              default: k = KEY_TOP;
                           endcase
                        end
                     endcase
                     j = i;
                     while (j > 0 && feed_key[p][j-1] > k) begin
                        feed_key[p][j] = feed_key[p][j-1];
                        j--;
                     end
                     feed_key[p][j] = k;
                  end
               end
               merge_finished = 1'b0;
               while (!merge_finished) begin
                  n = merge_width();
                  nc = 0;
                  for (p = 0; p < n; p++) begin
                     if (lane_waiting[p]) begin
                        cand[nc] = p;
                        nc++;
                     end
                  end
                  if (nc == 0 || $urandom_range(99) < 12) begin
                     beat = make_beat($urandom_range(MAX_PARTITIONS - 1), $urandom,
                                      $urandom, $urandom_range(7) == 0);
                  end else begin
                     p = cand[$urandom_range(nc - 1)];
                     if (feed_pos[p] < feed_len[p]) begin
                        beat = make_beat(p, feed_key[p][feed_pos[p]], $urandom, 1'b0);
                        feed_pos[p]++;
                     end else begin
                        beat = make_beat(p, $urandom, $urandom, 1'b1);
                     end
                  end
                  send_beat(beat, $urandom_range(63) == 0);
               end
            end
         end
      end
   endtask

   initial begin
      int i;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      mismatch_count = 0;
      records_taken = 0;
      merge_finished = 1'b0;
      active_csr = 5'd16;
      for (i = 0; i < MAX_PARTITIONS; i++) begin
         held_key[i] = '0;
         held_pay[i] = '0;
         lane_ended[i] = 1'b0;
         lane_waiting[i] = 1'b1;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_ties_and_extremes();
      test_width_edges();
      test_random_merges();
      settle();
      if (mismatch_count == 0) begin
         $display("k_way_merge_winner_tree verification clean");
      end else begin
         $display("k_way_merge_winner_tree verification failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("k_way_merge_winner_tree verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/kwm_pkg.sv
rtl/kwm_ctrl.sv
rtl/kwm_datapath.sv
rtl/k_way_merge_winner_tree.sv
tb/testbench.sv
